// ===== hw/rtl/gcm_pkg.sv =====
// ----------------------------------------------------------------------------
// gcm_pkg
// Types, codes and sizes shared by the greedy column mask block.
// ----------------------------------------------------------------------------
package gcm_pkg;

   localparam int ROWS        = 256;
   localparam int MAX_COLUMNS = 64;
   localparam int ROW_AW      = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CNT_W       = $clog2(ROWS + 1);

   // operation codes
   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_RUN   = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_MAX_DISTINCT = 2'd0;
   localparam logic [1:0] CSR_COLUMN_COUNT = 2'd1;
   localparam logic [1:0] CSR_START_MASK   = 2'd2;

   // result kinds
   localparam logic KIND_RUN   = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef struct packed {
      logic [1:0]  operation;
      logic [7:0]  row_index;
      logic [63:0] row_bits;
   } req_item_type;

   typedef struct packed {
      logic        result_kind;
      logic [63:0] final_mask;
      logic [8:0]  distinct_count;
      logic [7:0]  group_index;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROW_RD,
      ST_ROW_WAIT,
      ST_CMP,
      ST_PASS_DONE,
      ST_SCAN,
      ST_QRY
   } gcm_state_type;

   typedef enum logic [1:0] {
      PASS_BASE,
      PASS_CAND,
      PASS_FINAL
   } gcm_pass_type;

endpackage

// ===== hw/rtl/gcm_ram.sv =====
// ----------------------------------------------------------------------------
// gcm_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gcm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/greedy_column_mask_distinct_rows_top.sv =====
// ----------------------------------------------------------------------------
// greedy_column_mask_distinct_rows_top
// Row table with greedy column pruning that limits the distinct row count.
// ----------------------------------------------------------------------------
// Row loads: one item per cycle while idle and no result is held back, no result.
// Query: the group RAM read lands in ST_QRY, which registers the result.
// Run: each grouping pass walks the row RAM and the group representative RAM;
//   a run is one base pass, one pass per unmasked column per pruning round,
//   and one recording pass.
// Reset: synchronous; registers return to 16 / 64 / 0, mask and count to 0,
//   queries before the first run answer group 0. No clearing pass.
module greedy_column_mask_distinct_rows_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  gcm_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output gcm_pkg::rsp_item_type rsp_item,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [63:0]           csr_data
);
   import gcm_pkg::*;

   // configuration registers
   logic [8:0]  max_distinct_ff;
   logic [6:0]  column_count_ff;
   logic [63:0] start_mask_ff;

   // control state
   gcm_state_type state_ff, state_in;
   gcm_pass_type  pass_ff, pass_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          ran_ff, ran_in;
   logic [63:0]   cur_mask_ff, cur_mask_in;
   logic [8:0]    best_count_ff, best_count_in;

   // run datapath
   logic [ROW_AW-1:0] r_ff, r_in;
   logic [ROW_AW-1:0] g_ff, g_in;
   logic [CNT_W-1:0]  distinct_ff, distinct_in;
   logic [63:0]       row_ff, row_in;
   logic [63:0]       keep_ff, keep_in;
   logic [63:0]       mask_ff, mask_in;
   logic [CNT_W-1:0]  best_ff, best_in;
   logic [6:0]        col_ff, col_in;
   logic [5:0]        pick_ff, pick_in;
   logic              found_ff, found_in;
   logic              idx_ok_ff, idx_ok_in;
   rsp_item_type      rsp_item_ff, rsp_item_in;

   // memory ports
   logic              row_wr_en;
   logic [63:0]       row_rd;
   logic              rep_wr_en;
   logic [63:0]       rep_wr_data;
   logic [63:0]       rep_rd;
   logic              grp_wr_en;
   logic [ROW_AW-1:0] grp_wr_data;
   logic [ROW_AW-1:0] grp_rd;

   logic              req_fire;
   logic [6:0]        ncol;
   logic [63:0]       used;
   logic              match;
   logic [ROW_AW-1:0] row_group;
   logic              row_done;

   assign req_fire  = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // columns in use
   assign ncol  = (column_count_ff > 7'(MAX_COLUMNS)) ? 7'(MAX_COLUMNS) : column_count_ff;
   assign used  = (ncol >= 7'd64) ? '1 : ((64'd1 << ncol[5:0]) - 64'd1);
   assign match = (((row_ff ^ rep_rd) & keep_ff) == 64'd0);

   assign row_wr_en = req_fire && (req_item.operation == OP_LOAD)
                      && ({1'b0, req_item.row_index} < 9'(ROWS));

   // row table
   gcm_ram #(.WIDTH(64), .DEPTH(ROWS)) u_row_ram (
      .clock   (clock),
      .wr_en   (row_wr_en),
      .wr_addr (req_item.row_index[ROW_AW-1:0]),
      .wr_data (req_item.row_bits),
      .rd_addr (r_ff),
      .rd_data (row_rd)
   );

   // group representative rows
   gcm_ram #(.WIDTH(64), .DEPTH(ROWS)) u_rep_ram (
      .clock   (clock),
      .wr_en   (rep_wr_en),
      .wr_addr (distinct_ff[ROW_AW-1:0]),
      .wr_data (rep_wr_data),
      .rd_addr (g_in),
      .rd_data (rep_rd)
   );

   // recorded group of each row
   gcm_ram #(.WIDTH(ROW_AW), .DEPTH(ROWS)) u_grp_ram (
      .clock   (clock),
      .wr_en   (grp_wr_en),
      .wr_addr (r_ff),
      .wr_data (grp_wr_data),
      .rd_addr (req_item.row_index[ROW_AW-1:0]),
      .rd_data (grp_rd)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_distinct_ff <= 9'd16;
         column_count_ff <= 7'd64;
         start_mask_ff   <= 64'd0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAX_DISTINCT: max_distinct_ff <= csr_data[8:0];
            CSR_COLUMN_COUNT: column_count_ff <= csr_data[6:0];
            CSR_START_MASK:   start_mask_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pass_ff       <= PASS_BASE;
         rsp_valid_ff  <= 1'b0;
         ran_ff        <= 1'b0;
         cur_mask_ff   <= 64'd0;
         best_count_ff <= 9'd0;
      end else begin
         state_ff      <= state_in;
         pass_ff       <= pass_in;
         rsp_valid_ff  <= rsp_valid_in;
         ran_ff        <= ran_in;
         cur_mask_ff   <= cur_mask_in;
         best_count_ff <= best_count_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      r_ff        <= r_in;
      g_ff        <= g_in;
      distinct_ff <= distinct_in;
      row_ff      <= row_in;
      keep_ff     <= keep_in;
      mask_ff     <= mask_in;
      best_ff     <= best_in;
      col_ff      <= col_in;
      pick_ff     <= pick_in;
      found_ff    <= found_in;
      idx_ok_ff   <= idx_ok_in;
      rsp_item_ff <= rsp_item_in;
   end

   // sequencer: grouping passes and pruning rounds
   always_comb begin
      state_in      = state_ff;
      pass_in       = pass_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      ran_in        = ran_ff;
      cur_mask_in   = cur_mask_ff;
      best_count_in = best_count_ff;
      r_in          = r_ff;
      g_in          = g_ff;
      distinct_in   = distinct_ff;
      row_in        = row_ff;
      keep_in       = keep_ff;
      mask_in       = mask_ff;
      best_in       = best_ff;
      col_in        = col_ff;
      pick_in       = pick_ff;
      found_in      = found_ff;
      idx_ok_in     = idx_ok_ff;
      rsp_item_in   = rsp_item_ff;
      rep_wr_en     = 1'b0;
      rep_wr_data   = row_ff;
      grp_wr_en     = 1'b0;
      grp_wr_data   = '0;
      row_group     = g_ff;
      row_done      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_item.operation == OP_RUN)) begin
               mask_in     = start_mask_ff;
               keep_in     = used & ~start_mask_ff;
               pass_in     = PASS_BASE;
               r_in        = '0;
               distinct_in = '0;
               state_in    = ST_ROW_RD;
            end else if (req_fire && (req_item.operation == OP_QUERY)) begin
               idx_ok_in = ({1'b0, req_item.row_index} < 9'(ROWS));
               state_in  = ST_QRY;
            end
         end

         ST_ROW_RD: begin
            state_in = ST_ROW_WAIT;
         end

         // row data arrives; first row always opens a group
         ST_ROW_WAIT: begin
            row_in = row_rd;
            if (distinct_ff == '0) begin
               rep_wr_en   = 1'b1;
               rep_wr_data = row_rd;
               row_group   = '0;
               distinct_in = distinct_ff + 1'b1;
               row_done    = 1'b1;
            end else begin
               g_in     = '0;
               state_in = ST_CMP;
            end
         end

         // compare against one representative per cycle
         ST_CMP: begin
            if (match) begin
               row_group = g_ff;
               row_done  = 1'b1;
            end else if (CNT_W'(g_ff) + 1'b1 == distinct_ff) begin
               rep_wr_en   = 1'b1;
               row_group   = distinct_ff[ROW_AW-1:0];
               distinct_in = distinct_ff + 1'b1;
               row_done    = 1'b1;
            end else begin
               g_in = g_ff + 1'b1;
            end
         end

         ST_PASS_DONE: begin
            unique case (pass_ff)
               PASS_BASE: begin
                  if (9'(distinct_ff) > max_distinct_ff) begin
                     best_in  = distinct_ff;
                     col_in   = '0;
                     found_in = 1'b0;
                     state_in = ST_SCAN;
                  end else begin
                     pass_in     = PASS_FINAL;
                     keep_in     = used & ~mask_ff;
                     r_in        = '0;
                     distinct_in = '0;
                     state_in    = ST_ROW_RD;
                  end
               end
               PASS_CAND: begin
                  // ties go to the later column
                  if (distinct_ff <= best_ff) begin
                     best_in  = distinct_ff;
                     pick_in  = col_ff[5:0];
                     found_in = 1'b1;
                  end
                  col_in   = col_ff + 1'b1;
                  state_in = ST_SCAN;
               end
               PASS_FINAL: begin
                  cur_mask_in   = mask_ff;
                  best_count_in = 9'(distinct_ff);
                  ran_in        = 1'b1;
                  rsp_item_in.result_kind    = KIND_RUN;
                  rsp_item_in.final_mask     = mask_ff;
                  rsp_item_in.distinct_count = 9'(distinct_ff);
                  rsp_item_in.group_index    = 8'd0;
                  rsp_valid_in  = 1'b1;
                  state_in      = ST_IDLE;
               end
               default: state_in = ST_IDLE;
            endcase
         end

         // walk the columns, skipping masked ones
         ST_SCAN: begin
            if (col_ff == ncol) begin
               if (found_ff && (9'(best_ff) > max_distinct_ff)) begin
                  mask_in  = mask_ff | (64'd1 << pick_ff);
                  col_in   = '0;
                  found_in = 1'b0;
               end else begin
                  if (found_ff) begin
                     mask_in = mask_ff | (64'd1 << pick_ff);
                  end
                  keep_in     = used & ~(found_ff ? (mask_ff | (64'd1 << pick_ff)) : mask_ff);
                  pass_in     = PASS_FINAL;
                  r_in        = '0;
                  distinct_in = '0;
                  state_in    = ST_ROW_RD;
               end
            end else if (mask_ff[col_ff[5:0]]) begin
               col_in = col_ff + 1'b1;
            end else begin
               keep_in     = used & ~(mask_ff | (64'd1 << col_ff[5:0]));
               pass_in     = PASS_CAND;
               r_in        = '0;
               distinct_in = '0;
               state_in    = ST_ROW_RD;
            end
         end

         // group RAM data for the queried row
         ST_QRY: begin
            rsp_item_in.result_kind    = KIND_QUERY;
            rsp_item_in.final_mask     = cur_mask_ff;
            rsp_item_in.distinct_count = best_count_ff;
            rsp_item_in.group_index    = (ran_ff && idx_ok_ff) ? 8'(grp_rd) : 8'd0;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase

      // close out one row of a pass
      if (row_done) begin
         grp_wr_en   = (pass_ff == PASS_FINAL);
         grp_wr_data = row_group;
         if (r_ff == ROW_AW'(ROWS - 1)) begin
            state_in = ST_PASS_DONE;
         end else begin
            r_in     = r_ff + 1'b1;
            state_in = ST_ROW_RD;
         end
      end
   end

   // checks
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff == ST_IDLE))
      else $error("input taken while busy");

   a_group_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> (CNT_W'(g_ff) < distinct_ff))
      else $error("compare beyond open groups");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PASS_DONE) |-> (distinct_ff <= CNT_W'(ROWS)) && (distinct_ff != '0))
      else $error("pass count out of range");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_PASS_DONE || state_ff == ST_QRY))
      else $error("result without run or query");

endmodule

// ===== dv/greedy_column_mask_distinct_rows_checker.sv =====
// ----------------------------------------------------------------------------
// greedy_column_mask_distinct_rows_checker
// Watches the request, result and register channels, predicts each result
// with its own greedy pruning model and compares it field by field.
// ----------------------------------------------------------------------------
module greedy_column_mask_distinct_rows_checker
   import gcm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  req_item_type req_item,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsp_item_type rsp_item,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [63:0]  csr_data,
   output int           errors
);

   // mirrored block state
   logic [63:0] table_rows [ROWS];
   logic [7:0]  group_leader [ROWS];
   logic [7:0]  group_of_row [ROWS];
   logic [63:0] pruned_mask;
   logic [8:0]  pruned_count;
   logic [8:0]  limit_distinct;
   logic [6:0]  used_columns;
   logic [63:0] preset_mask;

   rsp_item_type expected_rsps[$];
   int           mismatches;

   // leftover expectations count as failures too
   assign errors = mismatches + expected_rsps.size();

   // first-match grouping over the kept columns
   function automatic int unsigned count_distinct(logic [63:0] keep, bit record);
      int unsigned distinct;
      int unsigned g;
      distinct = 0;
      for (int r = 0; r < ROWS; r++) begin
         for (g = 0; g < distinct; g++) begin
            if (((table_rows[r] ^ table_rows[group_leader[g]]) & keep) == 64'd0) break;
         end
         if (record) group_of_row[r] = 8'(g);
         if (g == distinct) begin
            group_leader[distinct] = 8'(r);
            distinct++;
         end
      end
      return distinct;
   endfunction

   // greedy pruning run, returns the run result
   function automatic rsp_item_type predict_run();
      rsp_item_type res;
      int unsigned  ncol, m, best, pick, a;
      logic [63:0]  used, mask, bit_c;
      bit           found;
      ncol = (used_columns > MAX_COLUMNS) ? MAX_COLUMNS : used_columns;
      used = (ncol >= 64) ? '1 : ((64'd1 << ncol) - 64'd1);
      mask = preset_mask;
      m = count_distinct(used & ~mask, 1'b0);
      while (m > limit_distinct) begin
         best  = m;
         pick  = 0;
         found = 1'b0;
         for (int unsigned c = 0; c < ncol; c++) begin
            bit_c = 64'd1 << c;
            if ((mask & bit_c) == 64'd0) begin
               a = count_distinct(used & ~(mask | bit_c), 1'b0);
               if (a <= best) begin
                  best  = a;
                  pick  = c;
                  found = 1'b1;
               end
            end
         end
         if (!found) break;
         mask |= 64'd1 << pick;
         m = best;
      end
      m = count_distinct(used & ~mask, 1'b1);
      pruned_mask  = mask;
      pruned_count = 9'(m);
      res.result_kind    = KIND_RUN;
      res.final_mask     = pruned_mask;
      res.distinct_count = pruned_count;
      res.group_index    = 8'd0;
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         for (int i = 0; i < ROWS; i++) begin
            table_rows[i]   = 64'd0;
            group_leader[i] = 8'd0;
            group_of_row[i] = 8'd0;
         end
         pruned_mask    = 64'd0;
         pruned_count   = 9'd0;
         limit_distinct = 9'd16;
         used_columns   = 7'd64;
         preset_mask    = 64'd0;
         expected_rsps.delete();
         mismatches     = 0;
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MAX_DISTINCT: limit_distinct = csr_data[8:0];
               CSR_COLUMN_COUNT: used_columns   = csr_data[6:0];
               CSR_START_MASK:   preset_mask    = csr_data;
               default: ;
            endcase
         end
         // accepted requests
         if (req_valid && req_ready) begin
            case (req_item.operation)
               OP_LOAD:  table_rows[req_item.row_index] = req_item.row_bits;
               OP_RUN:   expected_rsps.push_back(predict_run());
               OP_QUERY: begin
                  want.result_kind    = KIND_QUERY;
                  want.final_mask     = pruned_mask;
                  want.distinct_count = pruned_count;
                  want.group_index    = group_of_row[req_item.row_index];
                  expected_rsps.push_back(want);
               end
               default: ;
            endcase
         end
         // accepted results
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected result item: %p", rsp_item);
               mismatches++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_item.result_kind !== want.result_kind) begin
                  $error("result_kind expected %0d actual %0d",
                         want.result_kind, rsp_item.result_kind);
                  mismatches++;
               end
               if (rsp_item.final_mask !== want.final_mask) begin
                  $error("final_mask expected %h actual %h",
                         want.final_mask, rsp_item.final_mask);
                  mismatches++;
               end
               if (rsp_item.distinct_count !== want.distinct_count) begin
                  $error("distinct_count expected %0d actual %0d",
                         want.distinct_count, rsp_item.distinct_count);
                  mismatches++;
               end
               if (rsp_item.group_index !== want.group_index) begin
                  $error("group_index expected %0d actual %0d",
                         want.group_index, rsp_item.group_index);
                  mismatches++;
               end
            end
         end
      end
   end

endmodule

// ===== dv/greedy_column_mask_distinct_rows_top_tb.sv =====
// ----------------------------------------------------------------------------
// greedy_column_mask_distinct_rows_top_tb
// Drives loads, pruning runs and group queries with random gaps and result
// stalls, steps through register settings while idle, and reports a verdict.
// ----------------------------------------------------------------------------
module greedy_column_mask_distinct_rows_top_tb;
   import gcm_pkg::*;

   localparam logic [1:0] OP_UNUSED  = 2'd3;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = '0;
   logic [63:0]  csr_data = '0;
   int           errors;
   int           pending = 0;
   bit           req_burst = 1'b0;
   bit           rsp_burst = 1'b0;
   logic [63:0]  palette [8];

   always #4 clock = ~clock;

   greedy_column_mask_distinct_rows_top uut (.*);

   greedy_column_mask_distinct_rows_checker scoreboard (.*);

   // results still owed by the block
   always @(posedge clock) begin
      if (reset) pending <= 0;
      else pending <= pending
         + ((req_valid && req_ready &&
             (req_item.operation == OP_RUN || req_item.operation == OP_QUERY)) ? 1 : 0)
         - ((rsp_valid && rsp_ready) ? 1 : 0);
   end

   // result side stalls
   initial begin
      int gap;
      forever begin
         gap = rsp_burst ? 0 : $urandom_range(0, 10);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_item(logic [1:0] op, logic [7:0] idx, logic [63:0] bits);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_item.operation <= op;
      req_item.row_index <= idx;
      req_item.row_bits  <= bits;
      do @(posedge clock); while (!req_ready);
   endtask

   // let the block drain before touching registers
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_regs(logic [8:0] maxd, logic [6:0] cols, logic [63:0] smask);
      wait_idle();
      write_reg(CSR_MAX_DISTINCT, 64'(maxd));
      write_reg(CSR_COLUMN_COUNT, 64'(cols));
      write_reg(CSR_START_MASK, smask);
   endtask

   task automatic load_palette();
      for (int r = 0; r < ROWS; r++)
         send_item(OP_LOAD, 8'(r), palette[$urandom_range(0, 7)]);
   endtask

   initial begin
      logic [6:0]  cols;
      logic [8:0]  maxd;
      logic [63:0] smask;
      int          pick;
      palette[0] = '0;
      palette[1] = '1;
      for (int i = 2; i < 8; i++) palette[i] = {$urandom, $urandom};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // queries before any run, unused operation
      send_item(OP_QUERY, 8'd0, '0);
      send_item(OP_QUERY, 8'd255, '1);
      send_item(OP_UNUSED, 8'd7, '1);

      // every row distinct, no pruning allowed
      for (int r = 0; r < ROWS; r++)
         send_item(OP_LOAD, 8'(r), (r == 0) ? 64'd0 : (r == 255) ? '1 :
                   {$urandom, 24'($urandom), 8'(r)});
      set_regs(9'd256, 7'd64, 64'd0);
      write_reg(CSR_UNUSED, '1);
      send_item(OP_RUN, 8'd0, '0);
      send_item(OP_QUERY, 8'd255, '0);
      send_item(OP_QUERY, 8'd1, '0);

      // few distinct patterns from here on
      load_palette();
      set_regs(9'd16, 7'd0, 64'd0);
      send_item(OP_RUN, 8'd3, '0);
      send_item(OP_QUERY, 8'd200, '0);
      // count beyond the column limit, zero allowed: masks everything left
      set_regs(9'd0, 7'd127, ~64'h3F);
      send_item(OP_RUN, 8'd0, '0);
      send_item(OP_QUERY, 8'd17, '0);
      set_regs(9'd1, 7'd3, 64'd0);
      send_item(OP_RUN, 8'd0, '0);
      send_item(OP_QUERY, 8'd128, '0);
      set_regs(9'd511, 7'd6, 64'hFFFF_0000_0000_0000);
      send_item(OP_RUN, 8'd0, '0);

      // random phases
      for (int phase = 0; phase < 10; phase++) begin
         pick = $urandom_range(0, 9);
         cols = (pick < 7) ? 7'(pick) : (pick == 7) ? 7'd7 : (pick == 8) ? 7'd64 : 7'd127;
         smask = (cols <= 6) ? {$urandom, $urandom} : ({$urandom, $urandom} | ~64'h3F);
         pick = $urandom_range(0, 5);
         maxd = (pick == 0) ? 9'd0 : (pick == 1) ? 9'd256 : (pick == 2) ? 9'd511 :
                9'($urandom_range(1, 12));
         set_regs(maxd, cols, smask);
         req_burst = ($urandom_range(0, 3) == 0);
         rsp_burst = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < 42; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 62)
               send_item(OP_LOAD, 8'($urandom),
                         ($urandom_range(0, 19) == 0) ? {$urandom, $urandom}
                                                      : palette[$urandom_range(0, 7)]);
            else if (pick < 92) send_item(OP_QUERY, 8'($urandom), {$urandom, $urandom});
            else if (pick < 96) send_item(OP_RUN, 8'($urandom), {$urandom, $urandom});
            else send_item(OP_UNUSED, 8'($urandom), {$urandom, $urandom});
            // hold off until the block has answered everything
            if (n == 20 && phase == 3) wait_idle();
         end
         req_burst = 1'b0;
         rsp_burst = 1'b0;
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (errors == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

   // watchdog
   initial begin
      #1_000_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
